// ===== rtl/twe_pkg.sv =====
// Shared types and constants for the trace window edge generator.
package twe_pkg;

  // Register reset values
  localparam logic [4:0] DEPTH_RESET = 5'd8;
  localparam logic [5:0] SHIFT_RESET = 6'd20;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_SHIFT   = 1'b1;

  // Field widths
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned CFG_W   = 6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

endpackage

// ===== rtl/twe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module twe_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/trace_window_edge_generator.sv =====
// Top level of the trace window edge generator.
//
// Each input beat carries a 64-bit trace value, which is shifted right by
// align_shift to form a vertex. For every vertex held in the history (most
// recent first) one output beat leaves with the pair (history vertex, new
// vertex), tlast marking the final one; the new vertex is then pushed to
// the front of the history, which is trimmed to history_depth entries
// (capped at MAX_HISTORY). An input that meets an empty history gives no
// output beat. The history lives in a ring buffer in one RAM with a single
// registered read port, read one entry per cycle unless the output side
// stalls. The input side stays closed while an item is taken, its stored
// vertices are read and the new vertex is written back; edges leave at one
// per cycle while the output side is ready. The history needs no clearing
// pass after reset, since only entries already written are ever read.
module trace_window_edge_generator #(
  parameter int unsigned MAX_HISTORY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [twe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [twe_pkg::CFG_W-1:0]        cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [63:0]                      s_axis_tdata,  // [63:0] trace_value
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [127:0]                     m_axis_tdata,  // [63:0] source_vertex,
                                                          // [127:64] target_vertex
  output logic                             m_axis_tlast   // last_edge
);

  localparam int unsigned IdxW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int unsigned CntW = $clog2(MAX_HISTORY + 1);
  localparam int unsigned CmpW = (CntW + 1 > 5) ? CntW + 1 : 5;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_HISTORY - 1);
  localparam logic [CmpW-1:0] MaxCnt  = CmpW'(MAX_HISTORY);

  localparam int unsigned VW = twe_pkg::VALUE_W;

  twe_pkg::state_e state_q, state_d;

  logic [twe_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [twe_pkg::SHIFT_W-1:0] shift_q, shift_d;
  logic [IdxW-1:0]             head_q, head_d;
  logic [IdxW-1:0]             rp_q, rp_d;
  logic [CntW-1:0]             rcnt_q, rcnt_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [VW-1:0]               vtx_q, vtx_d;

  // Read-data stage (RAM output) and output register
  logic          rv_q, rv_d;
  logic          rl_q, rl_d;
  logic [VW-1:0] rt_q, rt_d;
  logic          ov_q, ov_d;
  logic          ol_q, ol_d;
  logic [VW-1:0] os_q, os_d;
  logic [VW-1:0] ot_q, ot_d;

  logic            in_acc;
  logic            move;
  logic            issue;
  logic            last_rd;
  logic [IdxW-1:0] head_dec;
  logic [IdxW-1:0] rp_inc;
  logic [CmpW-1:0] eff_depth;
  logic [CmpW-1:0] cnt_inc;
  logic [CmpW-1:0] new_cnt;
  logic [VW-1:0]   rdata;
  logic            push;

  // Handshake and pipeline movement
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign move    = rv_q && (!ov_q || m_axis_tready);
  assign issue   = (state_q == twe_pkg::ST_READ) && (!rv_q || move);
  assign last_rd = (CntW'(rcnt_q + 1'b1) == count_q);
  assign push    = (state_q == twe_pkg::ST_PUSH);

  // Ring pointer arithmetic with wrap at the history size
  assign head_dec = (head_q == '0) ? LastIdx : IdxW'(head_q - 1'b1);
  assign rp_inc   = (rp_q == LastIdx) ? '0 : IdxW'(rp_q + 1'b1);

  // New fill level: one more than now, capped by the effective depth
  assign eff_depth = (CmpW'(depth_q) > MaxCnt) ? MaxCnt : CmpW'(depth_q);
  assign cnt_inc   = CmpW'(count_q) + CmpW'(1);
  assign new_cnt   = (cnt_inc > eff_depth) ? eff_depth : cnt_inc;

  twe_ram #(
    .Width (VW),
    .Depth (MAX_HISTORY)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (head_dec),
    .wdata_i (vtx_q),
    .re_i    (issue),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  // Configuration registers
  always_comb begin
    depth_d = depth_q;
    shift_d = shift_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        twe_pkg::REG_HISTORY_DEPTH: depth_d = cfg_data_i[twe_pkg::DEPTH_W-1:0];
        twe_pkg::REG_ALIGN_SHIFT:   shift_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: take a beat, read the history, write the new vertex back
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    rp_d    = rp_q;
    rcnt_d  = rcnt_q;
    count_d = count_q;
    vtx_d   = vtx_q;
    unique case (state_q)
      twe_pkg::ST_IDLE: begin
        if (in_acc) begin
          vtx_d   = s_axis_tdata >> shift_q;
          rp_d    = head_q;
          rcnt_d  = '0;
          state_d = (count_q != '0) ? twe_pkg::ST_READ : twe_pkg::ST_PUSH;
        end
      end
      twe_pkg::ST_READ: begin
        if (issue) begin
          rp_d   = rp_inc;
          rcnt_d = CntW'(rcnt_q + 1'b1);
          if (last_rd) begin
            state_d = twe_pkg::ST_PUSH;
          end
        end
      end
      twe_pkg::ST_PUSH: begin
        head_d  = head_dec;
        count_d = CntW'(new_cnt);
        state_d = twe_pkg::ST_IDLE;
      end
      default: state_d = twe_pkg::ST_IDLE;
    endcase
  end

  // Read-data stage tags and output register
  always_comb begin
    rv_d = rv_q;
    rl_d = rl_q;
    rt_d = rt_q;
    if (issue) begin
      rv_d = 1'b1;
      rl_d = last_rd;
      rt_d = vtx_q;
    end else if (move) begin
      rv_d = 1'b0;
    end

    ov_d = ov_q;
    ol_d = ol_q;
    os_d = os_q;
    ot_d = ot_q;
    if (move) begin
      ov_d = 1'b1;
      ol_d = rl_q;
      os_d = rdata;
      ot_d = rt_q;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twe_pkg::ST_IDLE;
      depth_q <= twe_pkg::DEPTH_RESET;
      shift_q <= twe_pkg::SHIFT_RESET;
      head_q  <= '0;
      rp_q    <= '0;
      rcnt_q  <= '0;
      count_q <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      shift_q <= shift_d;
      head_q  <= head_d;
      rp_q    <= rp_d;
      rcnt_q  <= rcnt_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    vtx_q <= vtx_d;
    rl_q  <= rl_d;
    rt_q  <= rt_d;
    ol_q  <= ol_d;
    os_q  <= os_d;
    ot_q  <= ot_d;
  end

  assign s_axis_tready = (state_q == twe_pkg::ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {ot_q, os_q};
  assign m_axis_tlast  = ol_q;

endmodule

// ===== rtl/twe_checker.sv =====
// Port-level checks for the trace window edge generator, bound to the top level.
module twe_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled output beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // One item is worked on at a time: the input closes after a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input stayed open after a beat was taken");

  // Edges of one item leave without a gap once the output side takes them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run of edges");

endmodule

bind trace_window_edge_generator twe_checker u_twe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
